// File: rtl/core/dvr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dvr_pkg;

	// Table geometry and cost format
	localparam int NODES     = 4;
	localparam int NODE_W    = 2;
	localparam int ADDR_W    = 2 * NODE_W;
	localparam int TBL_DEPTH = NODES * NODES;
	localparam int COST_W    = 10;
	localparam int CFG_IDX_W = 3;

	localparam logic [COST_W-1:0] INF_COST = COST_W'(999);

	// Update kinds
	localparam logic [1:0] KIND_INIT   = 2'd0;
	localparam logic [1:0] KIND_VECTOR = 2'd1;
	localparam logic [1:0] KIND_LINK   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SELF_ID        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOUR_MASK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_COST_0    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_COST_3    = 3'd5;

	typedef struct packed {
		logic [1:0]        kind;
		logic [NODE_W-1:0] sender;
		logic [COST_W-1:0] adv_cost_0;
		logic [COST_W-1:0] adv_cost_1;
		logic [COST_W-1:0] adv_cost_2;
		logic [COST_W-1:0] adv_cost_3;
		logic [COST_W-1:0] new_link_cost;
	} upd_t;

	typedef struct packed {
		logic [NODE_W-1:0] dest_node;
		logic [COST_W-1:0] min_cost_0;
		logic [COST_W-1:0] min_cost_1;
		logic [COST_W-1:0] min_cost_2;
		logic [COST_W-1:0] min_cost_3;
		logic              last;
	} pkt_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [COST_W-1:0]    data;
	} cfg_wr_t;

	typedef struct packed {
		logic [NODE_W-1:0]                self_id;
		logic [NODES-1:0]                 neighbour_mask;
		logic [NODES-1:0][COST_W-1:0]     link_cost;
	} cfg_regs_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [COST_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} ram_req_t;

endpackage

`default_nettype wire

// File: rtl/core/dvr_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dvr_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/core/distance_vector_route_update.sv
`timescale 1ns / 1ps
`default_nettype none

// Distance-vector routing update for one router node.
// Channels: update (sink) takes init, received-vector and link-change items;
// packet (source) sends one routing packet per neighbour with the current row
// minima, in ascending node order, last set on the final one; cfg (sink)
// writes self_id, neighbour_mask and link_cost_0..3 by index, and is always
// ready. Transfers complete when valid and ready are both high.
// Timing: one item at a time. An init item takes 16 table writes, a vector or
// link-change item takes 1 diagonal read plus 4 read/write pairs on the
// column; both then sweep the 16 entries through the single table read port
// and, for an init or when a minimum changed, broadcast to each neighbour in
// ascending order, waiting on any packet stall. An unused kind is dropped
// and update ready stays high. Update ready is high again once the last
// packet is loaded into the output register.
// Reset: the distance table reads as infinity (999) until written, the minima
// are 999, the registers take their defaults and no packet is pending.
// A stalled packet holds in the output register; the broadcast waits on it.
module distance_vector_route_update
	import dvr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	dvr_chan_if.sink   update,
	dvr_chan_if.source packet,
	dvr_chan_if.sink   cfg
);

	cfg_regs_t         cfg_q;
	ram_req_t          ram_req;
	logic [COST_W-1:0] ram_rd_data;
	cfg_wr_t           cfg_wr;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.payload;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.self_id        <= NODE_W'(1);
			cfg_q.neighbour_mask <= NODES'(5);
			cfg_q.link_cost      <= {COST_W'(999), COST_W'(1), COST_W'(0), COST_W'(1)};
		end else if (cfg.valid) begin
			priority if (cfg_wr.index == REG_SELF_ID) begin
				cfg_q.self_id <= cfg_wr.data[NODE_W-1:0];
			end else if (cfg_wr.index == REG_NEIGHBOUR_MASK) begin
				cfg_q.neighbour_mask <= cfg_wr.data[NODES-1:0];
			end else if (cfg_wr.index >= REG_LINK_COST_0 &&
					cfg_wr.index <= REG_LINK_COST_3) begin
				cfg_q.link_cost[NODE_W'(cfg_wr.index - REG_LINK_COST_0)] <= cfg_wr.data;
			end else begin
			end
		end
	end

	dvr_ram #(
		.WIDTH (COST_W),
		.DEPTH (TBL_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (ram_rd_data)
	);

	dvr_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_regs    (cfg_q),
		.update      (update),
		.packet      (packet),
		.ram_req     (ram_req),
		.ram_rd_data (ram_rd_data)
	);

endmodule

`default_nettype wire

// File: rtl/core/dvr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dvr_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dvr_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module dvr_engine
	import dvr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_regs_t         cfg_regs,
	dvr_chan_if.sink               update,
	dvr_chan_if.source             packet,
	output ram_req_t               ram_req,
	input  wire logic [COST_W-1:0] ram_rd_data
);

	typedef enum logic [8:0] {
		ST_IDLE      = 9'b000000001,
		ST_INIT      = 9'b000000010,
		ST_DIAG      = 9'b000000100,
		ST_COL_RD    = 9'b000001000,
		ST_COL_WR    = 9'b000010000,
		ST_SWEEP     = 9'b000100000,
		ST_SWEEP_END = 9'b001000000,
		ST_DECIDE    = 9'b010000000,
		ST_BCAST     = 9'b100000000
	} state_t;

	state_t                       state_q;
	logic [ADDR_W-1:0]            cnt_q;
	logic [1:0]                   kind_q;
	logic [NODE_W-1:0]            snd_q;
	logic [NODES-1:0][COST_W-1:0] adv_q;
	logic [COST_W-1:0]            nc_q;
	logic [COST_W-1:0]            diag_q;
	logic                         is_init_q;
	logic                         chg_q;
	logic [NODES-1:0][COST_W-1:0] min_q;
	logic [COST_W-1:0]            run_min_q;
	logic [TBL_DEPTH-1:0]         ent_vld_q;
	logic                         hit_s1;
	logic                         sw_vld_s1;
	logic [ADDR_W-1:0]            sw_addr_s1;
	logic                         pkt_valid_q;
	pkt_t                         pkt_q;

	logic [COST_W-1:0] tbl_rd;
	logic [COST_W-1:0] init_lc;
	logic [COST_W-1:0] init_val;
	logic [COST_W:0]   vec_sum;
	logic [COST_W-1:0] vec_new;
	logic signed [COST_W+1:0] lk_sum;
	logic [COST_W-1:0] lk_new;
	logic [COST_W-1:0] col_new;
	logic [COST_W-1:0] sw_cur;
	logic [NODES-1:0]  elig;
	logic [NODES-1:0]  above;
	logic [NODE_W-1:0] bc_node;
	logic              slot_free;
	logic              upd_xfer;

	assign update.ready = (state_q == ST_IDLE);
	assign upd_xfer     = update.valid && update.ready;
	assign packet.valid   = pkt_valid_q;
	assign packet.payload = pkt_q;

	// Entries never written read as infinity
	assign tbl_rd = hit_s1 ? ram_rd_data : INF_COST;

	// Initial table value: diagonal from link costs, infinity elsewhere
	assign init_lc  = cfg_regs.link_cost[cnt_q[NODE_W-1:0]];
	assign init_val = (cnt_q[ADDR_W-1:NODE_W] == cnt_q[NODE_W-1:0]) ?
		((init_lc > INF_COST) ? INF_COST : init_lc) : INF_COST;

	// Vector update: link cost plus advertised cost, saturated
	assign vec_sum = {1'b0, diag_q} + {1'b0, adv_q[cnt_q[NODE_W-1:0]]};
	assign vec_new = (vec_sum > {1'b0, INF_COST}) ? INF_COST : vec_sum[COST_W-1:0];

	// Link change: shift entry by the diagonal offset, clamp to 0..infinity
	assign lk_sum = $signed({2'b00, nc_q}) + $signed({2'b00, tbl_rd})
		- $signed({2'b00, diag_q});
	always_comb begin
		if (lk_sum < 0) begin
			lk_new = '0;
		end else if (lk_sum > $signed({2'b00, INF_COST})) begin
			lk_new = INF_COST;
		end else begin
			lk_new = lk_sum[COST_W-1:0];
		end
	end

	assign col_new = (kind_q == KIND_VECTOR) ? vec_new : lk_new;

	// Running row minimum over the sweep
	assign sw_cur = (sw_addr_s1[NODE_W-1:0] == '0 || tbl_rd < run_min_q) ?
		tbl_rd : run_min_q;

	// Broadcast targets: mask without self
	assign elig      = cfg_regs.neighbour_mask &
		~(NODES'(1) << cfg_regs.self_id);
	assign bc_node   = cnt_q[NODE_W-1:0];
	assign above     = elig >> bc_node;
	assign slot_free = !pkt_valid_q || packet.ready;

	// Table access per state
	always_comb begin
		ram_req = '0;
		unique case (state_q)
			ST_INIT: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = cnt_q;
				ram_req.wr_data = init_val;
			end
			ST_DIAG: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = {snd_q, snd_q};
			end
			ST_COL_RD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = {cnt_q[NODE_W-1:0], snd_q};
			end
			ST_COL_WR: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = {cnt_q[NODE_W-1:0], snd_q};
				ram_req.wr_data = col_new;
			end
			ST_SWEEP: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = cnt_q;
			end
			ST_IDLE, ST_SWEEP_END, ST_DECIDE, ST_BCAST: begin
			end
			default: begin
			end
		endcase
	end

	// Track written entries and tag each read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			hit_s1    <= 1'b0;
		end else begin
			if (ram_req.wr_en) begin
				ent_vld_q[ram_req.wr_addr] <= 1'b1;
			end
			if (ram_req.rd_en) begin
				hit_s1 <= ent_vld_q[ram_req.rd_addr];
			end
		end
	end

	// Latch the update item
	always_ff @(posedge clk) begin
		if (upd_xfer) begin
			kind_q <= update.payload.kind;
			snd_q  <= update.payload.sender;
			adv_q  <= {update.payload.adv_cost_3, update.payload.adv_cost_2,
				update.payload.adv_cost_1, update.payload.adv_cost_0};
			nc_q   <= update.payload.new_link_cost;
		end
		if (state_q == ST_COL_RD && cnt_q == '0) begin
			diag_q <= tbl_rd;
		end
		if (sw_vld_s1) begin
			run_min_q <= sw_cur;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			is_init_q  <= 1'b0;
			chg_q      <= 1'b0;
			min_q      <= {NODES{INF_COST}};
			sw_vld_s1  <= 1'b0;
			sw_addr_s1 <= '0;
		end else begin
			sw_vld_s1  <= (state_q == ST_SWEEP);
			sw_addr_s1 <= cnt_q;

			// Fold each returned entry into its row minimum
			if (sw_vld_s1 && sw_addr_s1[NODE_W-1:0] == NODE_W'(NODES - 1)) begin
				min_q[sw_addr_s1[ADDR_W-1:NODE_W]] <= sw_cur;
				if (sw_cur != min_q[sw_addr_s1[ADDR_W-1:NODE_W]]) begin
					chg_q <= 1'b1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (upd_xfer) begin
						cnt_q     <= '0;
						chg_q     <= 1'b0;
						is_init_q <= (update.payload.kind == KIND_INIT);
						if (update.payload.kind == KIND_INIT) begin
							state_q <= ST_INIT;
						end else if (update.payload.kind == KIND_VECTOR ||
								update.payload.kind == KIND_LINK) begin
							state_q <= ST_DIAG;
						end
					end
				end
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(TBL_DEPTH - 1)) begin
						state_q <= ST_SWEEP;
					end
				end
				ST_DIAG: begin
					state_q <= ST_COL_RD;
				end
				ST_COL_RD: begin
					state_q <= ST_COL_WR;
				end
				ST_COL_WR: begin
					if (cnt_q[NODE_W-1:0] == NODE_W'(NODES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_SWEEP;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_COL_RD;
					end
				end
				ST_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ADDR_W'(TBL_DEPTH - 1)) begin
						state_q <= ST_SWEEP_END;
					end
				end
				ST_SWEEP_END: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (is_init_q || chg_q) begin
						state_q <= ST_BCAST;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_BCAST: begin
					// Advance past a node once its packet is loaded or it is skipped
					if (!elig[bc_node] || slot_free) begin
						cnt_q <= cnt_q + 1'b1;
						if (bc_node == NODE_W'(NODES - 1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: load a packet, drop it after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_q <= 1'b0;
		end else if (state_q == ST_BCAST && elig[bc_node] && slot_free) begin
			pkt_valid_q <= 1'b1;
		end else if (packet.ready) begin
			pkt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BCAST && elig[bc_node] && slot_free) begin
			pkt_q.dest_node  <= bc_node;
			pkt_q.min_cost_0 <= min_q[0];
			pkt_q.min_cost_1 <= min_q[1];
			pkt_q.min_cost_2 <= min_q[2];
			pkt_q.min_cost_3 <= min_q[3];
			pkt_q.last       <= (above[NODES-1:1] == '0);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/dvr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dvr_checker
	import dvr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic upd_valid,
	input wire logic upd_ready,
	input wire upd_t upd_payload,
	input wire logic pkt_valid,
	input wire logic pkt_ready,
	input wire pkt_t pkt_payload
);

	// A stalled packet stays offered
	a_pkt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_ready |=> pkt_valid)
		else $error("packet withdrawn while stalled");

	// No packet is pending while reset is held
	a_rst_idle: assert property (@(posedge clk)
		!arst_n |-> !pkt_valid)
		else $error("packet valid during reset");

	// A new update waits until the broadcast has reached its last packet
	a_burst_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_payload.last |-> !upd_ready)
		else $error("update taken during broadcast");

	// A valid update kind starts work and drops ready
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		upd_valid && upd_ready && (upd_payload.kind == KIND_INIT ||
			upd_payload.kind == KIND_VECTOR || upd_payload.kind == KIND_LINK)
		|=> !upd_ready)
		else $error("ready held after update transfer");

	// Advertised minima never exceed infinity
	a_cost_range: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid |-> pkt_payload.min_cost_0 <= INF_COST &&
			pkt_payload.min_cost_1 <= INF_COST &&
			pkt_payload.min_cost_2 <= INF_COST &&
			pkt_payload.min_cost_3 <= INF_COST)
		else $error("minimum cost above infinity");

endmodule

bind distance_vector_route_update dvr_checker u_dvr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.upd_valid   (update.valid),
	.upd_ready   (update.ready),
	.upd_payload (update.payload),
	.pkt_valid   (packet.valid),
	.pkt_ready   (packet.ready),
	.pkt_payload (packet.payload)
);

`default_nettype wire

// File: tb/sv/tb_distance_vector_route_update.sv
`timescale 1ns / 1ps

module tb_distance_vector_route_update;
	import dvr_pkg::*;

	localparam int CYCLE_LIMIT    = 400_000;
	localparam int QUIET_CYCLES   = 64;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int IDLE_PCT       = 21;
	localparam int MAX_REPORTS    = 100;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_ITEMS    = 28;
	localparam int INF            = INF_COST;
	localparam int COST_MAX       = (1 << COST_W) - 1;

	localparam logic [1:0]           KIND_UNUSED  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef logic [NODES-1:0][COST_W-1:0] cost_vec_t;

	// One line of the directed table: a register write or an update item,
	// with the broadcast typed in where it is obvious
	typedef struct packed {
		logic             is_reg;
		cfg_wr_t          wr;
		upd_t             item;
		logic             typed;
		logic [NODES-1:0] exp_dests;
		cost_vec_t        exp_min;
	} stim_row_t;

	logic clk;
	logic arst_n;

	dvr_chan_if #(.payload_t(upd_t))    upd_if ();
	dvr_chan_if #(.payload_t(pkt_t))    pkt_if ();
	dvr_chan_if #(.payload_t(cfg_wr_t)) cfg_if ();

	distance_vector_route_update u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.update (upd_if),
		.packet (pkt_if),
		.cfg    (cfg_if)
	);

	// Mirror of the node: distance table [dest][via], row minima, registers
	logic [COST_W-1:0] route_cost [NODES][NODES];
	logic [COST_W-1:0] best_cost [NODES];
	logic [NODE_W-1:0] node_self;
	logic [NODES-1:0]  nbr_mask;
	logic [COST_W-1:0] link_init [NODES];

	pkt_t      adverts_due [$];
	stim_row_t directed_rows [$];
	int        mismatch_count;
	int        tx_idle_pct;
	int        rx_idle_pct;
	bit        rx_hold_req;
	int        rx_hold_left;
	int        cycle_count;

	// Clock: 10 ns period
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [COST_W-1:0] got,
			input logic [COST_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic logic [COST_W-1:0] cap_cost(input int c);
		return (c > INF) ? INF_COST : COST_W'(c);
	endfunction

	// Recompute row minima; report whether any of them moved
	function automatic bit refresh_best();
		logic [COST_W-1:0] m;
		bit changed;
		changed = 1'b0;
		for (int d = 0; d < NODES; d++) begin
			m = route_cost[d][0];
			for (int v = 1; v < NODES; v++)
				if (route_cost[d][v] < m) m = route_cost[d][v];
			if (m != best_cost[d]) changed = 1'b1;
			best_cost[d] = m;
		end
		return changed;
	endfunction

	// Apply one update to the mirror; return the nodes that get a packet
	function automatic logic [NODES-1:0] apply_route_update(input upd_t it);
		logic [COST_W-1:0] adv [NODES];
		logic [COST_W-1:0] col [NODES];
		int diag;
		int entry;
		int nc;
		int shifted;
		bit announce;
		adv[0] = it.adv_cost_0;
		adv[1] = it.adv_cost_1;
		adv[2] = it.adv_cost_2;
		adv[3] = it.adv_cost_3;
		announce = 1'b0;
		case (it.kind)
			KIND_INIT: begin
				for (int d = 0; d < NODES; d++)
					for (int v = 0; v < NODES; v++)
						route_cost[d][v] = (d == v) ? cap_cost(int'(link_init[d])) : INF_COST;
				void'(refresh_best());
				announce = 1'b1;
			end
			KIND_VECTOR: begin
				// the sender's column is link cost plus advertised cost, saturated
				diag = int'(route_cost[it.sender][it.sender]);
				for (int d = 0; d < NODES; d++)
					route_cost[d][it.sender] = cap_cost(diag + int'(adv[d]));
				announce = refresh_best();
			end
			KIND_LINK: begin
				// shift the whole column by the change of the diagonal, clamped both ways
				diag = int'(route_cost[it.sender][it.sender]);
				nc = int'(it.new_link_cost);
				for (int d = 0; d < NODES; d++) begin
					entry = int'(route_cost[d][it.sender]);
					shifted = nc + entry - diag;
					col[d] = (shifted < 0) ? '0 : cap_cost(shifted);
				end
				for (int d = 0; d < NODES; d++)
					route_cost[d][it.sender] = col[d];
				announce = refresh_best();
			end
			default: ;
		endcase
		return announce ? (nbr_mask & ~(NODES'(1) << node_self)) : '0;
	endfunction

	// Queue one packet per selected node, ascending, last on the final one
	function automatic void queue_adverts(input logic [NODES-1:0] dests, input cost_vec_t mins);
		pkt_t p;
		int remaining;
		remaining = $countones(dests);
		for (int v = 0; v < NODES; v++) begin
			if (dests[v]) begin
				remaining--;
				p.dest_node  = NODE_W'(v);
				p.min_cost_0 = mins[0];
				p.min_cost_1 = mins[1];
				p.min_cost_2 = mins[2];
				p.min_cost_3 = mins[3];
				p.last       = (remaining == 0);
				adverts_due.push_back(p);
			end
		end
	endfunction

	function automatic void apply_reg(input cfg_wr_t w);
		case (w.index)
			REG_SELF_ID:        node_self = w.data[NODE_W-1:0];
			REG_NEIGHBOUR_MASK: nbr_mask = w.data[NODES-1:0];
			default: begin
				if (w.index >= REG_LINK_COST_0 && w.index <= REG_LINK_COST_3)
					link_init[w.index - REG_LINK_COST_0] = w.data;
			end
		endcase
	endfunction

	function automatic stim_row_t item_row(input logic [1:0] k, input int s,
			input int a0, input int a1, input int a2, input int a3, input int nc);
		stim_row_t r;
		r = '0;
		r.item.kind          = k;
		r.item.sender        = NODE_W'(s);
		r.item.adv_cost_0    = COST_W'(a0);
		r.item.adv_cost_1    = COST_W'(a1);
		r.item.adv_cost_2    = COST_W'(a2);
		r.item.adv_cost_3    = COST_W'(a3);
		r.item.new_link_cost = COST_W'(nc);
		return r;
	endfunction

	function automatic stim_row_t with_adverts(input stim_row_t r, input logic [NODES-1:0] dests,
			input int m0, input int m1, input int m2, input int m3);
		r.typed      = 1'b1;
		r.exp_dests  = dests;
		r.exp_min[0] = COST_W'(m0);
		r.exp_min[1] = COST_W'(m1);
		r.exp_min[2] = COST_W'(m2);
		r.exp_min[3] = COST_W'(m3);
		return r;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
		stim_row_t r;
		r = '0;
		r.is_reg   = 1'b1;
		r.wr.index = idx;
		r.wr.data  = COST_W'(data);
		return r;
	endfunction

	// Mostly small costs, some unreachable, a few above infinity
	function automatic int cost_sample();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 75) return $urandom_range(0, 40);
		if (pick < 90) return INF;
		if (pick < 95) return $urandom_range(41, INF - 1);
		return $urandom_range(INF + 1, COST_MAX);
	endfunction

	// A sender advertises zero cost to itself
	function automatic int advert(input int d, input int s);
		return (d == s) ? 0 : cost_sample();
	endfunction

	task automatic wait_quiet();
		while (adverts_due.size() != 0) @(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COST_W-1:0] data);
		cfg_if.payload.index = idx;
		cfg_if.payload.data  = data;
		cfg_if.valid = 1'b1;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		apply_reg(cfg_if.payload);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Offer one update; on transfer, queue what it must broadcast
	task automatic send_update(input stim_row_t r);
		logic [NODES-1:0] dests;
		cost_vec_t mins;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			upd_if.valid = 1'b0;
			@(negedge clk);
		end
		upd_if.payload = r.item;
		upd_if.valid = 1'b1;
		@(posedge clk);
		while (!upd_if.ready) @(posedge clk);
		dests = apply_route_update(r.item);
		for (int d = 0; d < NODES; d++)
			mins[d] = best_cost[d];
		if (r.typed)
			queue_adverts(r.exp_dests, r.exp_min);
		else
			queue_adverts(dests, mins);
		@(negedge clk);
		upd_if.valid = 1'b0;
	endtask

	// Packet sink: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (rx_hold_req) begin
			rx_hold_left = RX_HOLD_CYCLES;
			rx_hold_req = 1'b0;
		end
		if (rx_hold_left > 0) begin
			pkt_if.ready = 1'b0;
			rx_hold_left--;
		end else begin
			pkt_if.ready = ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Check each packet transfer against the oldest one due
	always @(posedge clk) begin : packet_check
		pkt_t got;
		pkt_t want;
		if (arst_n && pkt_if.valid && pkt_if.ready) begin
			got = pkt_if.payload;
			if (adverts_due.size() == 0) begin
				report_mismatch($sformatf("packet to node %0d with none due", got.dest_node));
			end else begin
				want = adverts_due.pop_front();
				compare_field("dest_node", COST_W'(got.dest_node), COST_W'(want.dest_node));
				compare_field($sformatf("min_cost_0 (dest %0d)", want.dest_node),
					got.min_cost_0, want.min_cost_0);
				compare_field($sformatf("min_cost_1 (dest %0d)", want.dest_node),
					got.min_cost_1, want.min_cost_1);
				compare_field($sformatf("min_cost_2 (dest %0d)", want.dest_node),
					got.min_cost_2, want.min_cost_2);
				compare_field($sformatf("min_cost_3 (dest %0d)", want.dest_node),
					got.min_cost_3, want.min_cost_3);
				compare_field($sformatf("last (dest %0d)", want.dest_node),
					COST_W'(got.last), COST_W'(want.last));
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		bit settled;
		int counted;
		int pick;
		int s;
		int c;
		stim_row_t row;

		arst_n = 1'b1;
		upd_if.valid = 1'b0;
		upd_if.payload = '0;
		pkt_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.payload = '0;
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct = IDLE_PCT;
		rx_hold_req = 1'b0;
		rx_hold_left = 0;
		mismatch_count = 0;

		// Assert reset with a clean falling edge before the first clock
		#1 arst_n = 1'b0;

		// Mirror starts from the reset state
		for (int d = 0; d < NODES; d++) begin
			best_cost[d] = INF_COST;
			for (int v = 0; v < NODES; v++)
				route_cost[d][v] = INF_COST;
		end
		node_self = 2'd1;
		nbr_mask = 4'd5;
		link_init[0] = 10'd1;
		link_init[1] = 10'd0;
		link_init[2] = 10'd1;
		link_init[3] = 10'd999;

		// Directed table, default registers first
		// vector before any init: link cost is infinite, nothing moves
		directed_rows.push_back(with_adverts(item_row(KIND_VECTOR, 0, 0, 1, 5, 2, 0),
			4'b0000, INF, INF, INF, INF));
		directed_rows.push_back(with_adverts(item_row(KIND_INIT, 0, 0, 0, 0, 0, 0),
			4'b0101, 1, 0, 1, INF));
		directed_rows.push_back(with_adverts(item_row(KIND_VECTOR, 0, 0, 1, 5, 2, 0),
			4'b0101, 1, 0, 1, 3));
		// sums saturate and no minimum changes
		directed_rows.push_back(with_adverts(item_row(KIND_VECTOR, 2, INF, INF, 0, INF, 0),
			4'b0000, INF, INF, INF, INF));
		// advertised costs above infinity
		directed_rows.push_back(item_row(KIND_VECTOR, 2, COST_MAX, COST_MAX, COST_MAX, COST_MAX, 0));
		directed_rows.push_back(item_row(KIND_LINK, 0, 0, 0, 0, 0, 5));
		directed_rows.push_back(item_row(KIND_VECTOR, 0, 500, 0, 0, 0, 0));
		// link drop below the column offset clamps at zero
		directed_rows.push_back(item_row(KIND_LINK, 0, 0, 0, 0, 0, 0));
		// new cost above infinity clamps at infinity
		directed_rows.push_back(item_row(KIND_LINK, 3, 0, 0, 0, 0, COST_MAX));
		directed_rows.push_back(item_row(KIND_LINK, 1, 0, 0, 0, 0, 0));
		// unused kind is dropped
		directed_rows.push_back(with_adverts(
			item_row(KIND_UNUSED, 3, COST_MAX, COST_MAX, COST_MAX, COST_MAX, COST_MAX),
			4'b0000, INF, INF, INF, INF));
		directed_rows.push_back(item_row(KIND_VECTOR, 1, 0, 0, 0, 0, 0));

		// Self inside the mask, extreme link costs, spare indexes
		directed_rows.push_back(reg_row(REG_SELF_ID, 'h3FC));
		directed_rows.push_back(reg_row(REG_NEIGHBOUR_MASK, 'h3FF));
		directed_rows.push_back(reg_row(REG_LINK_COST_0, 0));
		directed_rows.push_back(reg_row(REG_LINK_COST_0 + 3'd1, COST_MAX));
		directed_rows.push_back(reg_row(REG_LINK_COST_0 + 3'd2, INF));
		directed_rows.push_back(reg_row(REG_LINK_COST_3, 0));
		directed_rows.push_back(reg_row(REG_SPARE_LO, 'h155));
		directed_rows.push_back(reg_row(REG_SPARE_HI, 'h2AA));
		directed_rows.push_back(with_adverts(item_row(KIND_INIT, 0, 0, 0, 0, 0, 0),
			4'b1110, 0, INF, INF, 0));
		directed_rows.push_back(with_adverts(item_row(KIND_VECTOR, 3, 0, 0, 0, 0, 0),
			4'b1110, 0, 0, 0, 0));
		directed_rows.push_back(item_row(KIND_LINK, 3, 0, 0, 0, 0, INF));

		// No neighbours: state moves, nothing is sent
		directed_rows.push_back(reg_row(REG_SELF_ID, 3));
		directed_rows.push_back(reg_row(REG_NEIGHBOUR_MASK, 0));
		directed_rows.push_back(with_adverts(item_row(KIND_INIT, 0, 0, 0, 0, 0, 0),
			4'b0000, INF, INF, INF, INF));
		directed_rows.push_back(item_row(KIND_VECTOR, 0, 7, 8, 9, 10, 0));

		// Only the self bit set, every link down
		directed_rows.push_back(reg_row(REG_NEIGHBOUR_MASK, 8));
		directed_rows.push_back(reg_row(REG_LINK_COST_0, INF));
		directed_rows.push_back(reg_row(REG_LINK_COST_0 + 3'd1, INF));
		directed_rows.push_back(reg_row(REG_LINK_COST_0 + 3'd2, INF));
		directed_rows.push_back(reg_row(REG_LINK_COST_3, INF));
		directed_rows.push_back(with_adverts(item_row(KIND_INIT, 0, 0, 0, 0, 0, 0),
			4'b0000, INF, INF, INF, INF));
		directed_rows.push_back(item_row(KIND_LINK, 2, 0, 0, 0, 0, 3));

		// Hold reset, then release it
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table; registers change only when the block is idle
		settled = 1'b1;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_reg) begin
				if (!settled) wait_quiet();
				settled = 1'b1;
				write_reg(directed_rows[i].wr.index, directed_rows[i].wr.data);
			end else begin
				send_update(directed_rows[i]);
				settled = 1'b0;
			end
		end

		// Random phases: fresh registers, an init, then mostly well-formed updates
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_quiet();
			write_reg(REG_SELF_ID, COST_W'($urandom_range(0, COST_MAX)));
			write_reg(REG_NEIGHBOUR_MASK, COST_W'($urandom_range(0, COST_MAX)));
			for (int k = 0; k < NODES; k++) begin
				if (p == 0) begin
					c = 0;
				end else if (p == 1) begin
					c = COST_MAX;
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 60) c = $urandom_range(1, 20);
					else if (pick < 80) c = INF;
					else if (pick < 90) c = 0;
					else c = $urandom_range(INF + 1, COST_MAX);
				end
				write_reg(REG_LINK_COST_0 + CFG_IDX_W'(k), COST_W'(c));
			end

			// one phase runs flat out, one holds the packet sink off
			tx_idle_pct = (p == 2) ? 0 : IDLE_PCT;
			rx_idle_pct = (p == 2) ? 0 : IDLE_PCT;
			if (p == 4) rx_hold_req = 1'b1;

			send_update(item_row(KIND_INIT, $urandom_range(0, NODES - 1), cost_sample(),
				cost_sample(), cost_sample(), cost_sample(), cost_sample()));
			counted = 1;
			while (counted < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				s = $urandom_range(0, NODES - 1);
				if (pick < 45)
					row = item_row(KIND_VECTOR, s, advert(0, s), advert(1, s), advert(2, s),
						advert(3, s), $urandom_range(0, COST_MAX));
				else if (pick < 75)
					row = item_row(KIND_LINK, s, $urandom_range(0, COST_MAX),
						$urandom_range(0, COST_MAX), $urandom_range(0, COST_MAX),
						$urandom_range(0, COST_MAX), cost_sample());
				else if (pick < 82)
					row = item_row(KIND_INIT, s, cost_sample(), cost_sample(), cost_sample(),
						cost_sample(), cost_sample());
				else if (pick < 92)
					row = item_row(KIND_VECTOR, s, $urandom_range(0, COST_MAX),
						$urandom_range(0, COST_MAX), $urandom_range(0, COST_MAX),
						$urandom_range(0, COST_MAX), $urandom_range(0, COST_MAX));
				else
					row = item_row(KIND_UNUSED, s, $urandom_range(0, COST_MAX),
						$urandom_range(0, COST_MAX), $urandom_range(0, COST_MAX),
						$urandom_range(0, COST_MAX), $urandom_range(0, COST_MAX));
				send_update(row);
				if (row.item.kind != KIND_UNUSED) counted++;
			end
		end

		// Drain and report
		wait_quiet();
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/core/dvr_pkg.sv
rtl/core/dvr_chan_if.sv
rtl/core/dvr_ram.sv
rtl/core/dvr_engine.sv
rtl/core/distance_vector_route_update.sv
rtl/core/dvr_checker.sv
tb/sv/tb_distance_vector_route_update.sv
